>>> hdl/assert_macros.svh
// Assertion macros shared by the mapper RTL; clock clk and reset rst are implied.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define CBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/cbm_pkg.sv
// Types, codes and helper functions for the cartridge bank mapper.
`timescale 1ns / 1ps

package cbm_pkg;

  localparam int MAP_W = 21;

  // Bus operation codes
  typedef enum logic [2:0] {
    FUNC_WRITE = 3'd0,
    FUNC_PRG   = 3'd1,
    FUNC_CHR   = 3'd2,
    FUNC_NT    = 3'd3,
    FUNC_TICK  = 3'd4
  } func_t;

  // Chip variant codes
  localparam logic [1:0] VARIANT_FIRST  = 2'd0;
  localparam logic [1:0] VARIANT_SINGLE = 2'd1;
  localparam logic [1:0] VARIANT_SECOND = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_VARIANT  = 2'd0;
  localparam logic [1:0] CFG_PRG_SIZE = 2'd1;
  localparam logic [1:0] CFG_CHR_SIZE = 2'd2;

  // Size limits (log2 bytes)
  localparam logic [4:0] PRG_LOG2_MIN = 5'd14;
  localparam logic [4:0] PRG_LOG2_MAX = 5'd21;
  localparam logic [4:0] CHR_LOG2_MIN = 5'd10;
  localparam logic [4:0] CHR_LOG2_MAX = 5'd18;

  // First chip write pages (addr[15:12])
  localparam logic [3:0] PAGE_PRG0 = 4'h8;
  localparam logic [3:0] PAGE_MODE = 4'h9;
  localparam logic [3:0] PAGE_PRG1 = 4'hA;
  localparam logic [3:0] PAGE_CHR  = 4'hB;

  // Second chip register addresses
  localparam logic [15:0] ADDR_PRG0      = 16'h8000;
  localparam logic [15:0] ADDR_PRG1      = 16'hA000;
  localparam logic [15:0] ADDR_SWAP      = 16'h9000;
  localparam logic [15:0] ADDR_MIRROR    = 16'h9001;
  localparam logic [15:0] ADDR_IRQ_CTRL  = 16'h9003;
  localparam logic [15:0] ADDR_IRQ_LOAD  = 16'h9004;
  localparam logic [15:0] ADDR_RELOAD_HI = 16'h9005;
  localparam logic [15:0] ADDR_RELOAD_LO = 16'h9006;
  localparam logic [12:0] ADDR_CHR_BASE  = 13'h1600;  // 0xB000 >> 3

  // Program windows (addr[15:13])
  localparam logic [2:0] WIN_BANK0 = 3'b100;
  localparam logic [2:0] WIN_BANK1 = 3'b101;
  localparam logic [2:0] WIN_FIX0  = 3'b110;
  localparam logic [2:0] WIN_FIX1  = 3'b111;

  // Second chip mirroring codes
  localparam logic [1:0] MIR_VERT = 2'd0;
  localparam logic [1:0] MIR_HORZ = 2'd2;

  // Bank state seen by the address translation
  typedef struct packed {
    logic [1:0][7:0] prog_bank;
    logic [7:0][7:0] char_bank;
    logic            swap;
    logic [1:0]      mirror;
  } map_state_t;

  function automatic logic is_second(input logic [1:0] variant);
    return variant >= VARIANT_SECOND;
  endfunction

  // Clamp a log2 size and expand it into an address mask
  function automatic logic [MAP_W-1:0] size_mask(input logic [4:0] lg,
                                                  input logic [4:0] lo,
                                                  input logic [4:0] hi);
    logic [4:0]       c;
    logic [MAP_W-1:0] m;
    c = (lg < lo) ? lo : ((lg > hi) ? hi : lg);
    for (int i = 0; i < MAP_W; i++) begin
      m[i] = (5'(i) < c);
    end
    return m;
  endfunction

endpackage

>>> hdl/cbm_regs.sv
// Bank, mirroring and IRQ counter registers of the mapper.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbm_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [2:0]          func,
  input  logic [15:0]         addr,
  input  logic [7:0]          data,
  input  logic [1:0]          variant,
  output cbm_pkg::map_state_t st,
  output logic                irq_line
);

  cbm_pkg::map_state_t st_next;
  logic [15:0] irq_count, irq_count_next;
  logic [15:0] reload_val, reload_val_next;
  logic        irq_enabled, irq_enabled_next;
  logic        irq_pending, irq_pending_next;
  logic        second;
  logic [15:0] count_dec;

  assign second    = cbm_pkg::is_second(variant);
  assign count_dec = irq_count - 16'd1;

  // Register write decode and counter tick
  always_comb begin
    st_next          = st;
    irq_count_next   = irq_count;
    reload_val_next  = reload_val;
    irq_enabled_next = irq_enabled;
    irq_pending_next = irq_pending;
    unique case (cbm_pkg::func_t'(func))
      cbm_pkg::FUNC_WRITE: begin
        if (second) begin
          if (addr == cbm_pkg::ADDR_PRG0 || addr == cbm_pkg::ADDR_PRG1) begin
            st_next.prog_bank[addr[13]] = data;
          end else if (addr[15:3] == cbm_pkg::ADDR_CHR_BASE) begin
            st_next.char_bank[addr[2:0]] = data;
          end else begin
            priority case (addr)
              cbm_pkg::ADDR_SWAP:      st_next.swap = data[7];
              cbm_pkg::ADDR_MIRROR:    st_next.mirror = data[7:6];
              cbm_pkg::ADDR_IRQ_CTRL: begin
                irq_enabled_next = data[7];
                irq_pending_next = 1'b0;
              end
              cbm_pkg::ADDR_IRQ_LOAD: begin
                irq_count_next   = reload_val;
                irq_pending_next = 1'b0;
              end
              cbm_pkg::ADDR_RELOAD_HI: reload_val_next = {data, reload_val[7:0]};
              cbm_pkg::ADDR_RELOAD_LO: reload_val_next = {reload_val[15:8], data};
              default: ;
            endcase
          end
        end else begin
          priority case (addr[15:12])
            cbm_pkg::PAGE_PRG0, cbm_pkg::PAGE_PRG1:
              st_next.prog_bank[addr[13]] = {3'b000, data[4:0]};
            cbm_pkg::PAGE_CHR:
              st_next.char_bank[addr[2:0]] = data;
            cbm_pkg::PAGE_MODE: begin
              if (variant != cbm_pkg::VARIANT_SINGLE) begin
                st_next.mirror = {1'b0, data[0]};
                st_next.swap   = data[1];
              end
            end
            default: ;
          endcase
        end
      end
      cbm_pkg::FUNC_TICK: begin
        if (second && irq_enabled && irq_count != 16'd0) begin
          irq_count_next = count_dec;
          if (count_dec == 16'd0) irq_pending_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Interrupt line after this word
  assign irq_line = second && irq_pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= '0;
      irq_count   <= '0;
      reload_val  <= '0;
      irq_enabled <= 1'b0;
      irq_pending <= 1'b0;
    end else if (step) begin
      st          <= st_next;
      irq_count   <= irq_count_next;
      reload_val  <= reload_val_next;
      irq_enabled <= irq_enabled_next;
      irq_pending <= irq_pending_next;
    end
  end

  `CBM_ASSERT_IMP(a_pend_rise, $rose(irq_pending), $past(irq_count) == 16'd1, "irq raised early")
  `CBM_ASSERT_IMP(a_count_move, !$past(rst) && irq_count != $past(irq_count), irq_count == $past(irq_count) - 16'd1 || irq_count == $past(reload_val), "irq counter jumped")

endmodule

>>> hdl/cbm_xlate.sv
// Program, character and nametable address translation.
`timescale 1ns / 1ps

module cbm_xlate (
  input  logic [2:0]                  func,
  input  logic [15:0]                 addr,
  input  logic [1:0]                  variant,
  input  logic [4:0]                  prg_size_log2,
  input  logic [4:0]                  chr_size_log2,
  input  cbm_pkg::map_state_t         st,
  output logic [cbm_pkg::MAP_W-1:0]   mapped
);

  localparam int W = cbm_pkg::MAP_W;

  logic [W-1:0] prg_mask, chr_mask;
  logic [15:0]  a_sw;
  logic [W-1:0] prg_off, prog_addr, char_addr;
  logic [W-1:0] nt_vert, nt_horz, nt_single, nt_addr;

  assign prg_mask = cbm_pkg::size_mask(prg_size_log2, cbm_pkg::PRG_LOG2_MIN,
                                       cbm_pkg::PRG_LOG2_MAX);
  assign chr_mask = cbm_pkg::size_mask(chr_size_log2, cbm_pkg::CHR_LOG2_MIN,
                                       cbm_pkg::CHR_LOG2_MAX);

  // Program: optional swap of the 0x8000 and 0xC000 windows
  assign a_sw = (st.swap && !addr[13]) ? (addr ^ 16'h4000) : addr;

  always_comb begin
    unique case (a_sw[15:13])
      cbm_pkg::WIN_BANK0: prg_off = {st.prog_bank[0], 13'd0};
      cbm_pkg::WIN_BANK1: prg_off = {st.prog_bank[1], 13'd0};
      cbm_pkg::WIN_FIX0:  prg_off = prg_mask & ~W'(21'h3FFF);
      cbm_pkg::WIN_FIX1:  prg_off = prg_mask & ~W'(21'h1FFF);
      default:            prg_off = '0;
    endcase
  end
  assign prog_addr = ({8'd0, a_sw[12:0]} | prg_off) & prg_mask;

  // Character: 1 KiB banks
  assign char_addr = {3'd0, st.char_bank[addr[12:10]], addr[9:0]} & chr_mask;

  // Nametable mirroring
  assign nt_vert   = {10'd0, addr[10:0]};
  assign nt_horz   = {10'd0, addr[11], addr[9:0]};
  assign nt_single = {11'd0, addr[9:0]};

  always_comb begin
    if (cbm_pkg::is_second(variant)) begin
      if (st.mirror == cbm_pkg::MIR_VERT)      nt_addr = nt_vert;
      else if (st.mirror == cbm_pkg::MIR_HORZ) nt_addr = nt_horz;
      else                                     nt_addr = nt_single;
    end else if (variant == cbm_pkg::VARIANT_SINGLE) begin
      nt_addr = nt_single;
    end else begin
      nt_addr = (st.mirror != 2'd0) ? nt_horz : nt_vert;
    end
  end

  always_comb begin
    unique case (cbm_pkg::func_t'(func))
      cbm_pkg::FUNC_PRG: mapped = prog_addr;
      cbm_pkg::FUNC_CHR: mapped = char_addr;
      cbm_pkg::FUNC_NT:  mapped = nt_addr;
      default:           mapped = '0;
    endcase
  end

endmodule

>>> hdl/cartridge_bank_mapper_irq.sv
// An accepted word passes through the input register, then the result register.
// Throughput: one word per cycle unless out_ready stalls; state updates per advance.
// Stalls on the output side back up through the result and input registers.
// Reset (synchronous, rst high) clears banks, modes and IRQ state, empties both stages,
// and sets the chip variant to 0 and both size registers to 17.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cartridge_bank_mapper_irq (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [15:0] addr,
  input  logic [7:0]  data,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] mapped_addr,
  output logic        irq_level
);

  logic [1:0] variant;
  logic [4:0] prg_size_log2, chr_size_log2;

  logic        s1_valid;
  logic [2:0]  s1_func;
  logic [15:0] s1_addr;
  logic [7:0]  s1_data;
  logic        s1_advance;

  cbm_pkg::map_state_t st;
  logic                irq_line;
  logic [20:0]         mapped;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      variant       <= cbm_pkg::VARIANT_FIRST;
      prg_size_log2 <= 5'd17;
      chr_size_log2 <= 5'd17;
    end else if (cfg_we) begin
      priority case (cfg_index)
        cbm_pkg::CFG_VARIANT:  variant       <= cfg_data[1:0];
        cbm_pkg::CFG_PRG_SIZE: prg_size_log2 <= cfg_data;
        cbm_pkg::CFG_CHR_SIZE: chr_size_log2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func <= func;
      s1_addr <= addr;
      s1_data <= data;
    end
  end

  cbm_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_advance),
    .func     (s1_func),
    .addr     (s1_addr),
    .data     (s1_data),
    .variant  (variant),
    .st       (st),
    .irq_line (irq_line)
  );

  cbm_xlate u_xlate (
    .func          (s1_func),
    .addr          (s1_addr),
    .variant       (variant),
    .prg_size_log2 (prg_size_log2),
    .chr_size_log2 (chr_size_log2),
    .st            (st),
    .mapped        (mapped)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      mapped_addr <= mapped;
      irq_level   <= irq_line;
    end
  end

  `CBM_ASSERT_IMP(a_stall_cause, !in_ready, s1_valid && out_valid && !out_ready, "input stalled without a full pipe")
  `CBM_ASSERT_NEXT(a_advance_lands, s1_advance, out_valid, "advanced word not in result register")

endmodule

>>> verif/cbm_checker.sv
// Checker for the cartridge bank mapper: predicts every result word and compares it.
`timescale 1ns / 1ps

module cbm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  func,
  input  logic [15:0] addr,
  input  logic [7:0]  data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [20:0] mapped_addr,
  input  logic        irq_level,
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic [20:0] mapped;
    logic        irq;
  } result_t;

  localparam logic [4:0]  RESET_LOG2 = 5'd17;
  localparam logic [21:0] WIN_SIZE   = 22'h2000;

  // Shadow copy of the mapper configuration and bank state
  logic [1:0]  chip;
  logic [4:0]  prg_lg;
  logic [4:0]  chr_lg;
  logic [7:0]  prog_bank [2];
  logic [7:0]  char_bank [8];
  logic        swap;
  logic [1:0]  mirror;
  logic [15:0] irq_cnt;
  logic [15:0] reload_val;
  logic        irq_en;
  logic        irq_pend;

  result_t expected_q[$];
  int      fail_count = 0;

  assign errors = fail_count;

  // Memory size in bytes after clamping the log2 setting
  function automatic logic [21:0] size_bytes(input logic [4:0] lg, input logic [4:0] lo,
                                             input logic [4:0] hi);
    logic [4:0] c;
    c = lg;
    if (lg < lo) c = lo;
    else if (lg > hi) c = hi;
    return 22'd1 << c;
  endfunction

  function automatic logic [20:0] prog_addr(input logic [15:0] a);
    logic [15:0] sa;
    logic [21:0] size;
    logic [21:0] base;
    size = size_bytes(prg_lg, cbm_pkg::PRG_LOG2_MIN, cbm_pkg::PRG_LOG2_MAX);
    sa = a;
    // swap mode trades the 0x8000 and 0xC000 windows
    if (swap && !sa[13]) sa[14] = ~sa[14];
    case (sa[15:13])
      cbm_pkg::WIN_BANK0: base = 22'(prog_bank[0]) << 13;
      cbm_pkg::WIN_BANK1: base = 22'(prog_bank[1]) << 13;
      cbm_pkg::WIN_FIX0:  base = size - (WIN_SIZE << 1);
      cbm_pkg::WIN_FIX1:  base = size - WIN_SIZE;
      default:            base = '0;
    endcase
    return 21'((22'(sa[12:0]) | base) & (size - 22'd1));
  endfunction

  function automatic logic [20:0] char_addr(input logic [15:0] a);
    logic [21:0] size;
    size = size_bytes(chr_lg, cbm_pkg::CHR_LOG2_MIN, cbm_pkg::CHR_LOG2_MAX);
    return 21'({4'b0, char_bank[a[12:10]], a[9:0]} & (size - 22'd1));
  endfunction

  // Nametable mirroring: vertical, horizontal or single screen
  function automatic logic [20:0] nt_addr(input logic [15:0] a);
    logic [20:0] vert;
    logic [20:0] horz;
    logic [20:0] single;
    vert   = 21'(a[10:0]);
    horz   = 21'({a[11], a[9:0]});
    single = 21'(a[9:0]);
    if (chip >= cbm_pkg::VARIANT_SECOND) begin
      if (mirror == cbm_pkg::MIR_VERT) return vert;
      if (mirror == cbm_pkg::MIR_HORZ) return horz;
      return single;
    end
    if (chip == cbm_pkg::VARIANT_SINGLE) return single;
    return (mirror != 2'd0) ? horz : vert;
  endfunction

  // First chip decodes by page
  task automatic write_first(input logic [15:0] a, input logic [7:0] d);
    case (a[15:12])
      cbm_pkg::PAGE_PRG0, cbm_pkg::PAGE_PRG1: prog_bank[a[13]] = {3'b0, d[4:0]};
      cbm_pkg::PAGE_CHR:                      char_bank[a[2:0]] = d;
      cbm_pkg::PAGE_MODE: begin
        if (chip != cbm_pkg::VARIANT_SINGLE) begin
          mirror = {1'b0, d[0]};
          swap   = d[1];
        end
      end
      default: ;
    endcase
  endtask

  // Second chip decodes exact addresses
  task automatic write_second(input logic [15:0] a, input logic [7:0] d);
    if (a == cbm_pkg::ADDR_PRG0 || a == cbm_pkg::ADDR_PRG1) begin
      prog_bank[a[13]] = d;
    end else if (a[15:3] == cbm_pkg::ADDR_CHR_BASE) begin
      char_bank[a[2:0]] = d;
    end else begin
      case (a)
        cbm_pkg::ADDR_SWAP:      swap = d[7];
        cbm_pkg::ADDR_MIRROR:    mirror = d[7:6];
        cbm_pkg::ADDR_IRQ_CTRL: begin
          irq_en   = d[7];
          irq_pend = 1'b0;
        end
        cbm_pkg::ADDR_IRQ_LOAD: begin
          irq_cnt  = reload_val;
          irq_pend = 1'b0;
        end
        cbm_pkg::ADDR_RELOAD_HI: reload_val[15:8] = d;
        cbm_pkg::ADDR_RELOAD_LO: reload_val[7:0] = d;
        default: ;
      endcase
    end
  endtask

  // Apply one bus word to the shadow state and work out its result
  task automatic predict_word(input logic [2:0] f, input logic [15:0] a, input logic [7:0] d,
                              output result_t r);
    logic sec;
    sec = (chip >= cbm_pkg::VARIANT_SECOND);
    r.mapped = '0;
    case (f)
      cbm_pkg::FUNC_WRITE: begin
        if (sec) write_second(a, d);
        else write_first(a, d);
      end
      cbm_pkg::FUNC_PRG: r.mapped = prog_addr(a);
      cbm_pkg::FUNC_CHR: r.mapped = char_addr(a);
      cbm_pkg::FUNC_NT:  r.mapped = nt_addr(a);
      cbm_pkg::FUNC_TICK: begin
        if (sec && irq_en && irq_cnt != 16'd0) begin
          irq_cnt = irq_cnt - 16'd1;
          if (irq_cnt == 16'd0) irq_pend = 1'b1;
        end
      end
      default: ;
    endcase
    r.irq = sec && irq_pend;
  endtask

  // Bus monitor: config writes, result compare, then prediction of the new word
  always @(posedge clk) begin : watch_bus
    result_t want;
    int      n_out;
    if (rst) begin
      chip       = cbm_pkg::VARIANT_FIRST;
      prg_lg     = RESET_LOG2;
      chr_lg     = RESET_LOG2;
      prog_bank  = '{default: '0};
      char_bank  = '{default: '0};
      swap       = 1'b0;
      mirror     = '0;
      irq_cnt    = '0;
      reload_val = '0;
      irq_en     = 1'b0;
      irq_pend   = 1'b0;
      expected_q.delete();
      outstanding <= 0;
    end else begin
      n_out = 0;
      if (cfg_we) begin
        case (cfg_index)
          cbm_pkg::CFG_VARIANT:  chip = cfg_data[1:0];
          cbm_pkg::CFG_PRG_SIZE: prg_lg = cfg_data;
          cbm_pkg::CFG_CHR_SIZE: chr_lg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word, expected none, actual %h %b",
                   $time, mapped_addr, irq_level);
        end else begin
          want  = expected_q.pop_front();
          n_out = 1;
          if (want.mapped !== mapped_addr) begin
            fail_count++;
            $display("%0t: mapped_addr mismatch, expected %h, actual %h",
                     $time, want.mapped, mapped_addr);
          end
          if (want.irq !== irq_level) begin
            fail_count++;
            $display("%0t: irq_level mismatch, expected %b, actual %b",
                     $time, want.irq, irq_level);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_word(func, addr, data, want);
        expected_q.push_back(want);
      end
      outstanding <= outstanding + ((in_valid && in_ready) ? 1 : 0) - n_out;
    end
  end

endmodule

>>> verif/tb_top.sv
// Testbench top for the cartridge bank mapper: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0] FUNC_SPARE_LO   = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI   = 3'd7;
  localparam logic [1:0] VARIANT_SPARE   = 2'd3;
  localparam logic [1:0] CFG_SPARE       = 2'd3;
  localparam int         NUM_PHASES      = 9;
  localparam int         WORDS_PER_PHASE = 105;
  localparam int         HOLD_CYCLES     = 300;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic [2:0]  func      = '0;
  logic [15:0] addr      = '0;
  logic [7:0]  data      = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [20:0] mapped_addr;
  logic        irq_level;

  int         errors;
  int         outstanding;
  int         words_sent  = 0;
  int         tx_burst    = 0;
  bit         hold_go     = 1'b0;
  logic [1:0] cur_variant = cbm_pkg::VARIANT_FIRST;

  cartridge_bank_mapper_irq u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .addr       (addr),
    .data       (data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mapped_addr(mapped_addr),
    .irq_level  (irq_level)
  );

  cbm_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .addr       (addr),
    .data       (data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mapped_addr(mapped_addr),
    .irq_level  (irq_level),
    .errors     (errors),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input logic [2:0] f, input logic [15:0] a, input logic [7:0] d);
    int gap;
    int r;
    if (tx_burst > 0) begin
      tx_burst--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        tx_burst = $urandom_range(40, 120);
        gap = 0;
      end else if (r < 55) begin
        gap = 0;
      end else if (r < 94) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(10, 40);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    addr     <= a;
    data     <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [4:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Stop offering and wait until every expected result word is back
  task automatic drain_wait();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (outstanding != 0 && waited < 20000);
    repeat (6) @(posedge clk);
  endtask

  // One random bus word, biased toward the register pages of the active chip
  task automatic rand_word(output logic [2:0] f, output logic [15:0] a, output logic [7:0] d);
    int r;
    r = $urandom_range(0, 99);
    a = 16'($urandom);
    d = 8'($urandom);
    if (r < 30) begin
      f = cbm_pkg::FUNC_WRITE;
      if ($urandom_range(0, 9) < 7) begin
        if (cur_variant >= cbm_pkg::VARIANT_SECOND) begin
          case ($urandom_range(0, 8))
            0: a = cbm_pkg::ADDR_PRG0;
            1: a = cbm_pkg::ADDR_PRG1;
            2: a = cbm_pkg::ADDR_SWAP;
            3: a = cbm_pkg::ADDR_MIRROR;
            4: a = cbm_pkg::ADDR_IRQ_CTRL;
            5: a = cbm_pkg::ADDR_IRQ_LOAD;
            6: a = cbm_pkg::ADDR_RELOAD_HI;
            7: a = cbm_pkg::ADDR_RELOAD_LO;
            default: a = {cbm_pkg::ADDR_CHR_BASE, 3'($urandom)};
          endcase
        end else begin
          case ($urandom_range(0, 3))
            0: a = {cbm_pkg::PAGE_PRG0, 12'($urandom)};
            1: a = {cbm_pkg::PAGE_PRG1, 12'($urandom)};
            2: a = {cbm_pkg::PAGE_MODE, 12'($urandom)};
            default: a = {cbm_pkg::PAGE_CHR, 12'($urandom)};
          endcase
        end
      end
    end else if (r < 50) begin
      f = cbm_pkg::FUNC_PRG;
      if ($urandom_range(0, 4) != 0) a[15] = 1'b1;
    end else if (r < 68) begin
      f = cbm_pkg::FUNC_CHR;
    end else if (r < 85) begin
      f = cbm_pkg::FUNC_NT;
    end else if (r < 95) begin
      f = cbm_pkg::FUNC_TICK;
    end else begin
      f = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
    end
  endtask

  // Result side: random stalls, full-rate stretches and one long hold-off
  initial begin : sink
    int r;
    int held;
    bit hold_done;
    hold_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready <= 1'b1;
          @(posedge clk);
        end else if (r < 64) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(30, 100)) @(posedge clk);
        end else if (r < 95) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(15, 50)) @(posedge clk);
        end
      end
    end
  end

  // Stimulus: one pass per configuration setting
  initial begin : stimulus
    logic [1:0]  v;
    logic [4:0]  p_lg;
    logic [4:0]  c_lg;
    logic [2:0]  f;
    logic [15:0] a;
    logic [7:0]  d;
    logic [15:0] reload;
    logic        en_bit;
    int          n;
    int          phase_end;
    bit          mid_drained;
    mid_drained = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          v = cbm_pkg::VARIANT_FIRST;
          p_lg = cbm_pkg::PRG_LOG2_MIN; c_lg = cbm_pkg::CHR_LOG2_MIN;
        end
        1: begin
          v = cbm_pkg::VARIANT_FIRST;
          p_lg = cbm_pkg::PRG_LOG2_MAX; c_lg = cbm_pkg::CHR_LOG2_MAX;
        end
        2: begin v = cbm_pkg::VARIANT_SINGLE; p_lg = 5'd17; c_lg = 5'd13; end
        3: begin
          v = cbm_pkg::VARIANT_SECOND;
          p_lg = cbm_pkg::PRG_LOG2_MAX; c_lg = cbm_pkg::CHR_LOG2_MAX;
        end
        4: begin
          v = cbm_pkg::VARIANT_SECOND;
          p_lg = cbm_pkg::PRG_LOG2_MIN; c_lg = cbm_pkg::CHR_LOG2_MIN;
        end
        5: begin v = VARIANT_SPARE;          p_lg = 5'd16; c_lg = 5'd15; end
        6: begin v = cbm_pkg::VARIANT_SECOND; p_lg = 5'd31; c_lg = 5'd0;  end
        7: begin v = cbm_pkg::VARIANT_FIRST;  p_lg = 5'd0;  c_lg = 5'd31; end
        default: begin v = cbm_pkg::VARIANT_SINGLE; p_lg = 5'd20; c_lg = 5'd17; end
      endcase

      // reconfigure only with the block idle
      drain_wait();
      write_cfg(cbm_pkg::CFG_VARIANT, {3'($urandom), v});
      write_cfg(cbm_pkg::CFG_PRG_SIZE, p_lg);
      write_cfg(cbm_pkg::CFG_CHR_SIZE, c_lg);
      if (phase == 6) write_cfg(CFG_SPARE, 5'($urandom));
      cfg_we <= 1'b0;
      cur_variant = v;

      // first chip corners: masked bank bits, swap, low and top windows, spare codes
      if (phase == 0) begin
        send_word(cbm_pkg::FUNC_WRITE, {cbm_pkg::PAGE_PRG0, 12'h000}, 8'hFF);
        send_word(cbm_pkg::FUNC_WRITE, {cbm_pkg::PAGE_PRG1, 12'hFFF}, 8'h1F);
        send_word(cbm_pkg::FUNC_WRITE, {cbm_pkg::PAGE_CHR, 12'h007}, 8'hFF);
        send_word(cbm_pkg::FUNC_WRITE, {cbm_pkg::PAGE_MODE, 12'h000}, 8'h03);
        send_word(cbm_pkg::FUNC_PRG, 16'h0000, 8'h00);
        send_word(cbm_pkg::FUNC_PRG, 16'h8000, 8'h00);
        send_word(cbm_pkg::FUNC_PRG, 16'hC000, 8'h00);
        send_word(cbm_pkg::FUNC_PRG, 16'hFFFF, 8'hFF);
        send_word(cbm_pkg::FUNC_CHR, 16'h1FFF, 8'h00);
        send_word(cbm_pkg::FUNC_NT, 16'hFFFF, 8'h00);
        send_word(cbm_pkg::FUNC_TICK, 16'h0000, 8'h00);
        send_word(FUNC_SPARE_HI, 16'hFFFF, 8'hFF);
        send_word(FUNC_SPARE_LO, 16'h0000, 8'h00);
      end

      // second chip: counter runs out, request cleared, odd mirroring, last bank
      if (phase == 3) begin
        send_word(cbm_pkg::FUNC_WRITE, cbm_pkg::ADDR_RELOAD_HI, 8'h00);
        send_word(cbm_pkg::FUNC_WRITE, cbm_pkg::ADDR_RELOAD_LO, 8'h02);
        send_word(cbm_pkg::FUNC_WRITE, cbm_pkg::ADDR_IRQ_LOAD, 8'h00);
        send_word(cbm_pkg::FUNC_WRITE, cbm_pkg::ADDR_IRQ_CTRL, 8'h80);
        send_word(cbm_pkg::FUNC_TICK, 16'h0000, 8'h00);
        send_word(cbm_pkg::FUNC_TICK, 16'hFFFF, 8'hFF);
        send_word(cbm_pkg::FUNC_WRITE, cbm_pkg::ADDR_IRQ_CTRL, 8'h00);
        send_word(cbm_pkg::FUNC_WRITE, cbm_pkg::ADDR_MIRROR, 8'hC0);
        send_word(cbm_pkg::FUNC_NT, 16'h0C00, 8'h00);
        send_word(cbm_pkg::FUNC_WRITE, {cbm_pkg::ADDR_CHR_BASE, 3'h7}, 8'hFF);
        send_word(cbm_pkg::FUNC_CHR, 16'hFFFF, 8'h00);
        send_word(cbm_pkg::FUNC_WRITE, cbm_pkg::ADDR_SWAP, 8'h80);
        send_word(cbm_pkg::FUNC_PRG, 16'h8000, 8'h00);
        hold_go = 1'b1;
      end

      phase_end = words_sent + WORDS_PER_PHASE;
      while (words_sent < phase_end) begin
        // one pause mid-phase until everything is back
        if (phase == 1 && !mid_drained && words_sent >= phase_end - 50) begin
          drain_wait();
          mid_drained = 1'b1;
        end
        if (cur_variant >= cbm_pkg::VARIANT_SECOND && $urandom_range(0, 3) == 0) begin
          // counter run: reload, load, control write, then ticks with some noise
          reload = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
          en_bit = ($urandom_range(0, 4) != 0);
          send_word(cbm_pkg::FUNC_WRITE, cbm_pkg::ADDR_RELOAD_HI, reload[15:8]);
          send_word(cbm_pkg::FUNC_WRITE, cbm_pkg::ADDR_RELOAD_LO, reload[7:0]);
          send_word(cbm_pkg::FUNC_WRITE, cbm_pkg::ADDR_IRQ_LOAD, 8'($urandom));
          send_word(cbm_pkg::FUNC_WRITE, cbm_pkg::ADDR_IRQ_CTRL, {en_bit, 7'($urandom)});
          n = ((reload > 16'd30) ? 30 : int'(reload)) + $urandom_range(0, 3);
          repeat (n) begin
            if ($urandom_range(0, 5) == 0) begin
              rand_word(f, a, d);
              send_word(f, a, d);
            end
            send_word(cbm_pkg::FUNC_TICK, 16'($urandom), 8'($urandom));
          end
        end else begin
          rand_word(f, a, d);
          send_word(f, a, d);
        end
      end
    end

    drain_wait();
    if (errors == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/cbm_pkg.sv
hdl/cbm_regs.sv
hdl/cbm_xlate.sv
hdl/cartridge_bank_mapper_irq.sv
verif/cbm_checker.sv
verif/tb_top.sv
